/* rtl/hed_pkg.sv */
// Shared constants and types for the HTML entity decoder.
`timescale 1ns / 1ps
`default_nettype none

package hed_pkg;

    localparam int NAME_COUNT   = 6;
    localparam int NAME_MAX_LEN = 6;
    localparam int NAME_IDX_W   = 3;
    localparam int POS_W        = 4;
    localparam int DIGIT_W      = 3;
    localparam int CODE_W       = 24;
    localparam int CP_W         = 21;
    localparam int COUNT_W      = 3;

    localparam logic [POS_W-1:0]   POS_MAX       = 4'd11;
    localparam logic [DIGIT_W-1:0] DEC_LIMIT     = 3'd7;
    localparam logic [DIGIT_W-1:0] HEX_LIMIT     = 3'd6;
    localparam logic [NAME_COUNT-1:0] CAND_ALL   = 6'b111111;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    // Name order: lt, gt, amp, quot, apos, nbsp. Unused slots are never compared.
    localparam logic [7:0] NAME_TEXT [NAME_COUNT][NAME_MAX_LEN] = '{
        '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
        '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
        '{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},
        '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B}
    };

    localparam logic [POS_W-1:0] NAME_LEN [NAME_COUNT] = '{
        4'd4, 4'd4, 4'd5, 4'd6, 4'd6, 4'd6
    };

    localparam logic [COUNT_W-1:0] NAME_OUT_LEN [NAME_COUNT] = '{
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2
    };

    localparam logic [7:0] NAME_OUT [NAME_COUNT][2] = '{
        '{8'h3C, 8'h00},
        '{8'h3E, 8'h00},
        '{8'h26, 8'h00},
        '{8'h22, 8'h00},
        '{8'h27, 8'h00},
        '{8'hC2, 8'hA0}
    };

    typedef struct packed {
        logic                  name_hit;
        logic [NAME_IDX_W-1:0] name_sel;
        logic                  num_ok;
        logic [CP_W-1:0]       code_point;
    } hed_decision_t;

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
        logic [3:0][7:0]    bytes;
    } hed_result_t;

endpackage

`default_nettype wire

/* rtl/html_entity_decoder.sv */
// Top level of the HTML entity decoder: input stage, tracker, encoder, result register.
//
//   channel   signals                                 transaction
//   char      char_valid/char_ready, char_byte,       one entity byte
//             is_final
//   res       res_valid/res_ready, valid_res,         one decoded entity
//             byte_count, utf8_byte0..utf8_byte3
//
// One byte per cycle unless the result register stalls; a final byte loads the result.
// Per-byte work is the name compare and one digit accumulate between the input
// register and the tracker state; the final byte also passes the UTF-8 encoder.
// Asynchronous active-low reset clears the valid flags of both stages and the tracker state.
// A final byte waits in the input stage only while the result register is full and stalled.
`timescale 1ns / 1ps
`default_nettype none

module html_entity_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       char_valid,
    output logic            char_ready,
    input  wire logic [7:0] char_byte,
    input  wire logic       is_final,
    output logic            res_valid,
    input  wire logic       res_ready,
    output logic            valid_res,
    output logic [2:0]      byte_count,
    output logic [7:0]      utf8_byte0,
    output logic [7:0]      utf8_byte1,
    output logic [7:0]      utf8_byte2,
    output logic [7:0]      utf8_byte3
);
    import hed_pkg::*;

    logic               s1_valid_reg, s1_valid_next;
    logic [7:0]         s1_byte_reg;
    logic               s1_final_reg;
    logic               res_valid_reg, res_valid_next;
    hed_result_t        res_reg;

    logic               char_accept;
    logic               out_free;
    logic               proc_fire;
    hed_decision_t      decision;
    hed_result_t        result;

    assign out_free    = !res_valid_reg || res_ready;
    assign proc_fire   = s1_valid_reg && (!s1_final_reg || out_free);
    assign char_ready  = !s1_valid_reg || proc_fire;
    assign char_accept = char_valid && char_ready;

    hed_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (proc_fire),
        .char_byte (s1_byte_reg),
        .is_final  (s1_final_reg),
        .decision  (decision)
    );

    hed_encoder u_encoder (
        .decision (decision),
        .result   (result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (char_accept)
            s1_valid_next = 1'b1;
        else if (proc_fire)
            s1_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (proc_fire && s1_final_reg)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_accept)
        begin
            s1_byte_reg  <= char_byte;
            s1_final_reg <= is_final;
        end
        if (proc_fire && s1_final_reg)
            res_reg <= result;
    end

    assign res_valid  = res_valid_reg;
    assign valid_res  = res_reg.valid;
    assign byte_count = res_reg.count;
    assign utf8_byte0 = res_reg.bytes[0];
    assign utf8_byte1 = res_reg.bytes[1];
    assign utf8_byte2 = res_reg.bytes[2];
    assign utf8_byte3 = res_reg.bytes[3];

    a_final_loads: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && s1_final_reg |=> res_valid_reg)
        else $error("final byte processed without a result");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !char_ready |-> s1_valid_reg && s1_final_reg && res_valid_reg && !res_ready)
        else $error("input stalled without a blocked result");

    a_count_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> valid_res == (byte_count != 3'd0))
        else $error("valid flag disagrees with byte count");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !valid_res |-> utf8_byte0 == 8'd0 && utf8_byte1 == 8'd0
            && utf8_byte2 == 8'd0 && utf8_byte3 == 8'd0)
        else $error("rejected entity carries nonzero bytes");

endmodule

`default_nettype wire

/* rtl/hed_tracker.sv */
// Per-byte tracking of name candidates and numeric reference state.
`timescale 1ns / 1ps
`default_nettype none

module hed_tracker (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            char_byte,
    input  wire logic                  is_final,
    output hed_pkg::hed_decision_t     decision
);
    import hed_pkg::*;

    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [NAME_COUNT-1:0] cand_reg, cand_next;
    logic                  hex_reg, hex_next;
    logic                  ok_reg, ok_next;
    logic [DIGIT_W-1:0]    dcount_reg, dcount_next;
    logic [CODE_W-1:0]     code_reg, code_next;

    logic [NAME_COUNT-1:0] match;
    logic [NAME_COUNT-1:0] cand_upd;
    logic [NAME_COUNT-1:0] hit;
    logic                  digit_ok;
    logic [3:0]            digit_val;
    logic [DIGIT_W-1:0]    limit;
    logic [CODE_W-1:0]     code_acc;
    logic                  cp_in_range;

    always_comb
    begin
        for (int i = 0; i < NAME_COUNT; i++)
        begin
            match[i] = (pos_reg < NAME_LEN[i])
                    && (NAME_TEXT[i][pos_reg[NAME_IDX_W-1:0]] == char_byte);
            hit[i]   = cand_reg[i] && match[i] && ((pos_reg + 4'd1) == NAME_LEN[i]);
        end
        cand_upd = cand_reg & match;
    end

    // Digit decode: letters share low nibble + 9 in either case.
    always_comb
    begin
        digit_ok  = 1'b0;
        digit_val = 4'd0;
        if (char_byte inside {[8'h30:8'h39]})
        begin
            digit_ok  = 1'b1;
            digit_val = char_byte[3:0];
        end
        else if (hex_reg && (char_byte inside {[8'h41:8'h46], [8'h61:8'h66]}))
        begin
            digit_ok  = 1'b1;
            digit_val = char_byte[3:0] + 4'd9;
        end
        limit = hex_reg ? HEX_LIMIT : DEC_LIMIT;
        if (hex_reg)
            code_acc = {code_reg[CODE_W-5:0], digit_val};
        else
            code_acc = {code_reg[CODE_W-4:0], 3'b000} + {code_reg[CODE_W-2:0], 1'b0}
                     + {{(CODE_W-4){1'b0}}, digit_val};
    end

    always_comb
    begin
        pos_next    = pos_reg;
        cand_next   = cand_reg;
        hex_next    = hex_reg;
        ok_next     = ok_reg;
        dcount_next = dcount_reg;
        code_next   = code_reg;
        if (step && is_final)
        begin
            pos_next    = '0;
            cand_next   = CAND_ALL;
            hex_next    = 1'b0;
            ok_next     = 1'b1;
            dcount_next = '0;
            code_next   = '0;
        end
        else if (step)
        begin
            cand_next = cand_upd;
            if (pos_reg == 4'd0)
            begin
                if (char_byte != CH_AMP)
                    ok_next = 1'b0;
            end
            else if (pos_reg == 4'd1)
            begin
                if (char_byte != CH_HASH)
                    ok_next = 1'b0;
            end
            else if (pos_reg == 4'd2 && (char_byte == CH_LOW_X || char_byte == CH_UP_X))
                hex_next = 1'b1;
            else if (!digit_ok || dcount_reg >= limit)
                ok_next = 1'b0;
            else
            begin
                code_next   = code_acc;
                dcount_next = dcount_reg + 3'd1;
            end
            if (pos_reg < POS_MAX)
                pos_next = pos_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            cand_reg   <= CAND_ALL;
            hex_reg    <= 1'b0;
            ok_reg     <= 1'b1;
            dcount_reg <= '0;
            code_reg   <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            cand_reg   <= cand_next;
            hex_reg    <= hex_next;
            ok_reg     <= ok_next;
            dcount_reg <= dcount_next;
            code_reg   <= code_next;
        end
    end

    // Nonzero, not a surrogate, at most 10FFFF.
    assign cp_in_range = (code_reg != '0)
                      && !(code_reg[CODE_W-1:11] == 13'h001B)
                      && (code_reg[CODE_W-1:CP_W] == '0)
                      && !(code_reg[20] && (code_reg[19:16] != 4'd0));

    always_comb
    begin
        decision            = '0;
        decision.name_hit   = |hit;
        for (int i = NAME_COUNT - 1; i >= 0; i--)
        begin
            if (hit[i])
                decision.name_sel = NAME_IDX_W'(i);
        end
        decision.num_ok     = ok_reg && (pos_reg >= 4'd3) && (char_byte == CH_SEMI)
                           && (dcount_reg != '0) && cp_in_range;
        decision.code_point = code_reg[CP_W-1:0];
    end

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && is_final |=> pos_reg == '0 && cand_reg == CAND_ALL && ok_reg && !hex_reg)
        else $error("tracker state not cleared after final byte");

    a_hex_digits: assert property (@(posedge clk) disable iff (!rst_n)
        hex_reg |-> dcount_reg <= HEX_LIMIT)
        else $error("hex digit count beyond limit");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(pos_reg) && $stable(code_reg) && $stable(cand_reg))
        else $error("tracker state changed without a byte");

endmodule

`default_nettype wire

/* rtl/hed_encoder.sv */
// Result formation: named entity bytes or UTF-8 encoding of the code point.
`timescale 1ns / 1ps
`default_nettype none

module hed_encoder (
    input  wire hed_pkg::hed_decision_t decision,
    output hed_pkg::hed_result_t        result
);
    import hed_pkg::*;

    logic [CP_W-1:0] cp;

    assign cp = decision.code_point;

    always_comb
    begin
        result = '0;
        if (decision.name_hit)
        begin
            result.valid    = 1'b1;
            result.count    = NAME_OUT_LEN[decision.name_sel];
            result.bytes[0] = NAME_OUT[decision.name_sel][0];
            result.bytes[1] = NAME_OUT[decision.name_sel][1];
        end
        else if (decision.num_ok)
        begin
            result.valid = 1'b1;
            if (cp[CP_W-1:7] == '0)
            begin
                result.count    = 3'd1;
                result.bytes[0] = {1'b0, cp[6:0]};
            end
            else if (cp[CP_W-1:11] == '0)
            begin
                result.count    = 3'd2;
                result.bytes[0] = {3'b110, cp[10:6]};
                result.bytes[1] = {2'b10, cp[5:0]};
            end
            else if (cp[CP_W-1:16] == '0)
            begin
                result.count    = 3'd3;
                result.bytes[0] = {4'b1110, cp[15:12]};
                result.bytes[1] = {2'b10, cp[11:6]};
                result.bytes[2] = {2'b10, cp[5:0]};
            end
            else
            begin
                result.count    = 3'd4;
                result.bytes[0] = {5'b11110, cp[20:18]};
                result.bytes[1] = {2'b10, cp[17:12]};
                result.bytes[2] = {2'b10, cp[11:6]};
                result.bytes[3] = {2'b10, cp[5:0]};
            end
        end
    end

endmodule

`default_nettype wire
